[design/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and helpers for the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int CHUNK_EDGE_DEF = 16;

  localparam int IDX_W   = 12;
  localparam int TYPE_W  = 8;
  localparam int WORD_W  = 26;
  localparam int DIR_W   = 3;
  localparam int SLOT_W  = 24;
  localparam int COORD_W = 4;
  localparam int STORE_DEPTH = 1 << IDX_W;
  localparam int FACES   = 6;

  // input function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // read step select: centre cube, then neighbours one to six
  localparam logic [2:0] SEL_CENTRE = 3'd0;
  localparam logic [2:0] SEL_LAST   = 3'd6;

  typedef struct packed {
    logic       load;     // capture a query word
    logic       wr;       // store a cube
    logic       rd_en;    // issue a store read
    logic [2:0] rd_sel;   // which cube to read
    logic       emit;     // push the next exposed face
  } vfc_cmd_t;

  typedef struct packed {
    logic cube_zero;
    logic mask_any;
    logic mask_last;      // at most one exposed face left
    logic out_free;
  } vfc_sts_t;

  // face code per scan position: -x, +x, -z, +z, -y, +y
  function automatic logic [DIR_W-1:0] face_code(input logic [2:0] k);
    case (k)
      3'd0:    face_code = 3'd2;
      3'd1:    face_code = 3'd3;
      3'd2:    face_code = 3'd1;
      3'd3:    face_code = 3'd0;
      3'd4:    face_code = 3'd4;
      3'd5:    face_code = 3'd5;
      default: face_code = 3'd0;
    endcase
  endfunction

  // neighbour offset per scan position, as {dx, dy, dz}, each -1, 0 or +1
  function automatic logic [8:0] nb_offset(input logic [2:0] k);
    case (k)
      3'd0:    nb_offset = {3'b111, 3'b000, 3'b000};
      3'd1:    nb_offset = {3'b001, 3'b000, 3'b000};
      3'd2:    nb_offset = {3'b000, 3'b000, 3'b111};
      3'd3:    nb_offset = {3'b000, 3'b000, 3'b001};
      3'd4:    nb_offset = {3'b000, 3'b111, 3'b000};
      3'd5:    nb_offset = {3'b000, 3'b001, 3'b000};
      default: nb_offset = 9'd0;
    endcase
  endfunction

endpackage

[design/vfc_if.sv]
// ----------------------------------------------------------------------------
// vfc_if
// Valid/ready channels of the voxel face culler: input words and face words.
// ----------------------------------------------------------------------------
interface vfc_in_if import vfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [IDX_W-1:0]  cube_index;
  logic [TYPE_W-1:0] cube_type;

  modport source (output valid, func, cube_index, cube_type, input ready);
  modport sink   (input valid, func, cube_index, cube_type, output ready);
endinterface

interface vfc_out_if import vfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] face_word;
  logic [DIR_W-1:0]  face_dir;
  logic [SLOT_W-1:0] slot_index;
  logic              last_face;

  modport source (output valid, face_word, face_dir, slot_index, last_face, input ready);
  modport sink   (input valid, face_word, face_dir, slot_index, last_face, output ready);
endinterface

[design/voxel_face_culler.sv]
// ----------------------------------------------------------------------------
// voxel_face_culler
// Hidden-face culling over one 16x16x16 chunk of 8-bit cube types.
// ----------------------------------------------------------------------------
// A write word is stored at once and the block stays ready for the next word.
// A query word keeps the block busy until its exposed faces (0 to 6) are
// emitted: the cube store has a single read port, so the centre cube and its
// six neighbours are read one per cycle, a drain state settles the last read,
// then one face is emitted per cycle while the face output is free to take it.
// Faces leave through a registered output, so a new word can be accepted
// while the final face still waits to be taken. The store has no reset; only
// cubes that were written may be queried or read as neighbours.
module voxel_face_culler import vfc_pkg::*; #(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vfc_in_if.sink     in_ch,
  vfc_out_if.source  out_ch
);

  vfc_cmd_t cmd;
  vfc_sts_t sts;

  vfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vfc_datapath #(
    .CHUNK_EDGE (CHUNK_EDGE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_cube_index (in_ch.cube_index),
    .in_cube_type  (in_ch.cube_type),
    .out_ch        (out_ch)
  );

endmodule

[design/vfc_ctrl.sv]
// ----------------------------------------------------------------------------
// vfc_ctrl
// Sequencer: accepts words, steps the seven store reads, then emits faces.
// ----------------------------------------------------------------------------
module vfc_ctrl import vfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_ready,
  input  vfc_sts_t sts,
  output vfc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.rd_sel = step_r;
    case (state_r)
      ST_IDLE: begin
        cmd.wr   = accept && (in_func == FUNC_WRITE);
        cmd.load = accept && (in_func == FUNC_QUERY);
        if (cmd.load) begin
          state_nxt = ST_READ;
          step_nxt  = SEL_CENTRE;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (step_r == SEL_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.cube_zero || !sts.mask_any) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.mask_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= SEL_CENTRE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[design/vfc_datapath.sv]
// ----------------------------------------------------------------------------
// vfc_datapath
// Cube store, neighbour address generation, exposure mask and face output.
// ----------------------------------------------------------------------------
module vfc_datapath import vfc_pkg::*; #(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vfc_cmd_t          cmd,
  output vfc_sts_t          sts,
  input  logic [IDX_W-1:0]  in_cube_index,
  input  logic [TYPE_W-1:0] in_cube_type,
  vfc_out_if.source         out_ch
);

  localparam logic [COORD_W:0] EDGE = (COORD_W+1)'(CHUNK_EDGE);

  logic [TYPE_W-1:0] store_mem [STORE_DEPTH];

  logic [IDX_W-1:0]  idx_r;
  logic [TYPE_W-1:0] rdata_r;
  logic [TYPE_W-1:0] cube_r;
  logic [2:0]        sel_d_r;
  logic              rd_v_r;
  logic              outside_d_r;
  logic [FACES-1:0]  mask_r, mask_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [DIR_W-1:0]  out_dir_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_last_r;

  logic [IDX_W-1:0]   rd_addr;
  logic               rd_outside;
  logic [8:0]         offs;
  logic [2:0]         nb_k;
  logic [COORD_W:0]   nx, ny, nz;
  logic [2:0]         pick;
  logic [FACES-1:0]   pick_bit;

  // neighbour coordinates; a step below zero wraps to 31, so one compare
  // against the edge covers both sides of the chunk
  always_comb begin
    nb_k = cmd.rd_sel - 3'd1;
    offs = nb_offset(nb_k);
    nx = {1'b0, idx_r[11:8]} + {{2{offs[8]}}, offs[8:6]};
    ny = {1'b0, idx_r[7:4]}  + {{2{offs[5]}}, offs[5:3]};
    nz = {1'b0, idx_r[3:0]}  + {{2{offs[2]}}, offs[2:0]};
    if (cmd.rd_sel == SEL_CENTRE) begin
      rd_addr    = idx_r;
      rd_outside = 1'b0;
    end else begin
      rd_addr    = {nx[3:0], ny[3:0], nz[3:0]};
      rd_outside = (nx >= EDGE) || (ny >= EDGE) || (nz >= EDGE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      store_mem[in_cube_index] <= in_cube_type;
    end
    rdata_r <= store_mem[rd_addr];
  end

  // lowest pending face in scan order
  always_comb begin
    pick = 3'd0;
    for (int k = FACES - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        pick = 3'(k);
      end
    end
    pick_bit = FACES'(1) << pick;
  end

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.load) begin
      mask_nxt = '0;
    end else if (rd_v_r && (sel_d_r != SEL_CENTRE)) begin
      mask_nxt[sel_d_r - 3'd1] = outside_d_r || (rdata_r == '0);
    end else if (cmd.emit) begin
      mask_nxt = mask_r & ~pick_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_cube_index;
    end
    sel_d_r     <= cmd.rd_sel;
    outside_d_r <= rd_outside;
    if (rd_v_r && (sel_d_r == SEL_CENTRE)) begin
      cube_r <= rdata_r;
    end
    mask_r <= mask_nxt;
    if (cmd.emit) begin
      out_word_r <= {cube_r, idx_r, 3'b000, face_code(pick)};
      out_dir_r  <= face_code(pick);
      out_slot_r <= slot_r;
      out_last_r <= ((mask_r & ~pick_bit) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
      if (cmd.emit) begin
        slot_r      <= slot_r + SLOT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.cube_zero = (cube_r == '0);
  assign sts.mask_any  = (mask_r != '0);
  assign sts.mask_last = ((mask_r & ~pick_bit) == '0);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.face_word  = out_word_r;
  assign out_ch.face_dir   = out_dir_r;
  assign out_ch.slot_index = out_slot_r;
  assign out_ch.last_face  = out_last_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ch.ready))
    else $error("face pushed over a word not yet taken");

  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_slot_r == slot_r - SLOT_W'(1)))
    else $error("slot number out of step with emitted face");

  a_dir_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r[2:0] == out_dir_r && out_dir_r <= 3'd5))
    else $error("face word direction disagrees with face code");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (mask_r != '0 && cube_r != '0))
    else $error("face emitted with no exposed face pending");

endmodule
